@@ rtl/core/weighted_3x3_smoothing_stencil_top_macros.svh @@
// assertion macros used by the stencil top module
`ifndef WEIGHTED_3X3_SMOOTHING_STENCIL_TOP_MACROS_SVH
`define WEIGHTED_3X3_SMOOTHING_STENCIL_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define WSS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define WSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/wss_pkg.sv @@
package wss_pkg;

  localparam int PIXEL_W      = 16;
  localparam int WEIGHT_W     = 16;
  localparam int SIZE_W       = 11;
  localparam int COORD_W      = 10;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int CORNER_SUM_W = PIXEL_W + 2;
  localparam int SIDE_SUM_W   = PIXEL_W + 2;
  localparam int ACC_W        = CORNER_SUM_W + WEIGHT_W + 2;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [SIZE_W-1:0]   SIZE_RST   = 11'd1024;
  localparam logic [WEIGHT_W-1:0] CORNER_RST = 16'd3277;
  localparam logic [WEIGHT_W-1:0] SIDE_RST   = 16'd6554;
  localparam logic [WEIGHT_W-1:0] CENTER_RST = 16'd26214;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIZE    = 4'd0,
    REG_CORNER_WEIGHT = 4'd1,
    REG_EDGE_WEIGHT   = 4'd2,
    REG_CENTER_WEIGHT = 4'd3
  } wss_reg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] corner;
    logic [WEIGHT_W-1:0] side;
    logic [WEIGHT_W-1:0] center;
  } wss_weights_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               interior;
    logic               last;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } wss_item_t;

  typedef struct packed {
    logic [CORNER_SUM_W-1:0] corners;
    logic [SIDE_SUM_W-1:0]   sides;
    logic [PIXEL_W-1:0]      centre;
    logic                    last;
    logic [COORD_W-1:0]      out_row;
    logic [COORD_W-1:0]      out_col;
  } wss_sums_t;

  // output word, low bits first: smoothed, out_row, out_col, zero fill
  typedef struct packed {
    logic [3:0]         pad;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [PIXEL_W-1:0] smoothed;
  } wss_out_t;

  localparam int OUT_TDATA_W = $bits(wss_out_t);

endpackage

@@ rtl/core/wss_ram.sv @@
module wss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/wss_window.sv @@
module wss_window #(
  parameter int MAX_WIDTH = wss_pkg::MAX_WIDTH_DEF,
  parameter int AW        = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wss_pkg::wss_item_t  in_item,
  input  logic [AW-1:0]       in_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output wss_pkg::wss_sums_t  out_sums
);

  import wss_pkg::*;

  logic               v1;
  wss_item_t          item1;
  logic [AW-1:0]      addr1;
  logic               accept;
  logic               move1;
  logic               ready2;
  logic [PIXEL_W-1:0] up1;
  logic [PIXEL_W-1:0] up2;
  logic [PIXEL_W-1:0] win [6];
  wss_sums_t          sums;

  assign ready2   = !out_valid || out_ready;
  assign move1    = v1 && (!item1.interior || ready2);
  assign in_ready = !v1 || move1;
  assign accept   = in_valid && in_ready;

  // row above and row two above, read on accept, written when the item leaves
  wss_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_up1_ram (
    .clk   (clk),
    .we    (move1),
    .waddr (addr1),
    .wdata (item1.pixel),
    .re    (accept),
    .raddr (in_addr),
    .rdata (up1)
  );

  wss_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_up2_ram (
    .clk   (clk),
    .we    (move1),
    .waddr (addr1),
    .wdata (up1),
    .re    (accept),
    .raddr (in_addr),
    .rdata (up2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (accept) begin
      item1 <= in_item;
      addr1 <= in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (move1) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= up2;
      win[1] <= up1;
      win[2] <= item1.pixel;
    end
  end

  always_comb begin
    sums.corners = CORNER_SUM_W'(win[3]) + CORNER_SUM_W'(win[5])
                 + CORNER_SUM_W'(up2) + CORNER_SUM_W'(item1.pixel);
    sums.sides   = SIDE_SUM_W'(win[4]) + SIDE_SUM_W'(win[0])
                 + SIDE_SUM_W'(win[2]) + SIDE_SUM_W'(up1);
    sums.centre  = win[1];
    sums.last    = item1.last;
    sums.out_row = item1.out_row;
    sums.out_col = item1.out_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= move1 && item1.interior;
    end
    if (ready2 && move1 && item1.interior) begin
      out_sums <= sums;
    end
  end

endmodule

@@ rtl/core/wss_mac.sv @@
module wss_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wss_pkg::wss_sums_t                  in_sums,
  input  wss_pkg::wss_weights_t               weights,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wss_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  import wss_pkg::*;

  localparam int PROD_W   = CORNER_SUM_W + WEIGHT_W;
  localparam int CPROD_W  = PIXEL_W + WEIGHT_W;
  localparam int ROUND_W  = ACC_W - 16;

  logic                  v3;
  logic [PROD_W-1:0]     p_corner;
  logic [PROD_W-1:0]     p_side;
  logic [CPROD_W-1:0]    p_center;
  logic                  last3;
  logic [COORD_W-1:0]    row3;
  logic [COORD_W-1:0]    col3;
  logic                  ready_o;
  logic [ACC_W-1:0]      acc;
  logic [ROUND_W-1:0]    rounded;
  logic [PIXEL_W-1:0]    sat;
  wss_out_t              word;

  assign ready_o  = !m_tvalid || m_tready;
  assign in_ready = !v3 || ready_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (in_ready) begin
      v3 <= in_valid;
    end
    if (in_ready && in_valid) begin
      p_corner <= PROD_W'(in_sums.corners) * PROD_W'(weights.corner);
      p_side   <= PROD_W'(in_sums.sides) * PROD_W'(weights.side);
      p_center <= CPROD_W'(in_sums.centre) * CPROD_W'(weights.center);
      last3    <= in_sums.last;
      row3     <= in_sums.out_row;
      col3     <= in_sums.out_col;
    end
  end

  // round half up to q0.16, then clip
  always_comb begin
    acc     = ACC_W'(p_corner) + ACC_W'(p_side) + ACC_W'(p_center) + ACC_W'(17'h08000);
    rounded = acc[ACC_W-1:16];
    sat     = (|rounded[ROUND_W-1:PIXEL_W]) ? '1 : rounded[PIXEL_W-1:0];
  end

  assign m_tdata = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready_o) begin
      m_tvalid <= v3;
    end
    if (ready_o && v3) begin
      word.pad      <= '0;
      word.out_col  <= col3;
      word.out_row  <= row3;
      word.smoothed <= sat;
      m_tlast       <= last3;
    end
  end

endmodule

@@ rtl/core/weighted_3x3_smoothing_stencil_top.sv @@
// 3x3 symmetric smoothing filter for a square image of n x n unsigned q0.16 pixels in raster
// order (n = image_size clamped to 3..MAX_WIDTH). One pixel is taken every clock unless the
// output stalls, with no gaps between rows or frames; the filtered value of interior pixel
// (r, c) leaves registered after pixel (r+1, c+1) is taken, tagged with its row and column,
// and tlast marks the last interior pixel of a frame. Border pixels give no output word. The
// two previous rows are held in two MAX_WIDTH-deep memories, each read and written once per
// pixel. Line memories are not cleared; the first two rows of a frame fill them. Writing
// image_size restarts the frame; registers may be written only while no pixel is in flight.
`include "weighted_3x3_smoothing_stencil_top_macros.svh"

module weighted_3x3_smoothing_stencil_top #(
  parameter int MAX_WIDTH = wss_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [wss_pkg::PIXEL_W-1:0]        s_tdata,   // pixel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [wss_pkg::OUT_TDATA_W-1:0]    m_tdata,   // smoothed, out_row, out_col, zero fill
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import wss_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int NW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

  logic [SIZE_W-1:0] image_size;
  wss_weights_t      weights;
  logic [AW-1:0]     column_count;
  logic [AW-1:0]     row_count;
  logic [CW-1:0]     size_ext;
  logic [NW-1:0]     n_eff;
  logic [NW-1:0]     n_m1;
  logic              col_last;
  logic              row_last;
  logic              accept;
  logic              cfg_we;
  logic              size_we;
  wss_item_t         item;
  logic              sums_valid;
  logic              sums_ready;
  wss_sums_t         sums;
  wss_out_t          out_word;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign size_we   = cfg_we && (cfg_index == REG_IMAGE_SIZE);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size     <= SIZE_RST;
      weights.corner <= CORNER_RST;
      weights.side   <= SIDE_RST;
      weights.center <= CENTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE:    image_size     <= cfg_data[SIZE_W-1:0];
        REG_CORNER_WEIGHT: weights.corner <= cfg_data[WEIGHT_W-1:0];
        REG_EDGE_WEIGHT:   weights.side   <= cfg_data[WEIGHT_W-1:0];
        REG_CENTER_WEIGHT: weights.center <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size_ext = CW'(image_size);
    if (size_ext < CW'(3)) begin
      size_ext = CW'(3);
    end else if (size_ext > CW'(MAX_WIDTH)) begin
      size_ext = CW'(MAX_WIDTH);
    end
    n_eff    = size_ext[NW-1:0];
    n_m1     = n_eff - NW'(1);
    col_last = NW'(column_count) >= n_m1;
    row_last = NW'(row_count) >= n_m1;
  end

  always_ff @(posedge clk) begin
    if (rst || size_we) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + AW'(1);
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

  always_comb begin
    item.pixel    = s_tdata;
    item.interior = (row_count >= AW'(2)) && (column_count >= AW'(2));
    item.last     = row_last && col_last;
    item.out_row  = COORD_W'(row_count - AW'(1));
    item.out_col  = COORD_W'(column_count - AW'(1));
  end

  wss_window #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .in_addr   (column_count),
    .out_valid (sums_valid),
    .out_ready (sums_ready),
    .out_sums  (sums)
  );

  wss_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sums_valid),
    .in_ready (sums_ready),
    .in_sums  (sums),
    .weights  (weights),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign out_word = m_tdata;

  `WSS_ASSERT_IMPLIES(a_col_in_frame, clk, rst, 1'b1, NW'(column_count) < n_eff, "column count outside frame")
  `WSS_ASSERT_NEXT(a_size_restarts, clk, rst, size_we, (column_count == '0) && (row_count == '0), "size write did not restart frame")
  `WSS_ASSERT_IMPLIES(a_last_on_diag, clk, rst, m_tvalid && m_tlast, out_word.out_row == out_word.out_col, "frame end off the diagonal")

endmodule
